/* rtl/core/npu_pkg.sv */
// ----------------------------------------------------------------------------
// npu_pkg
// Shared types, constants and helpers for the nibble pixel unpacker.
// ----------------------------------------------------------------------------
package npu_pkg;

  localparam int SPAN_W   = 11;   // width of row_bytes and row_count
  localparam int POS_W    = 10;   // width of the column and row positions
  localparam int PIX_W    = 8;    // width of one expanded pixel
  localparam int NIB_W    = 4;    // width of one packed pixel
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int MAX_SPAN = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TO_FF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_LAST_FOUR = 3'd4;

  localparam logic [SPAN_W-1:0] ROW_BYTES_RESET = 11'd160;
  localparam logic [SPAN_W-1:0] ROW_COUNT_RESET = 11'd240;

  localparam logic [PIX_W-1:0] ZERO_PIX_LOW  = 8'h00;
  localparam logic [PIX_W-1:0] ZERO_PIX_HIGH = 8'hFF;

  // Settings as the datapath sees them, derived from the raw registers.
  typedef struct packed {
    logic [POS_W-1:0] last_col;   // last byte position of a row
    logic [POS_W-1:0] last_row;   // last row of an image
    logic [POS_W-1:0] emit_last;  // last byte position that gives a result
    logic             has_emit;   // false when dropping eats the whole row
    logic             drop;
    logic [PIX_W-1:0] palette_offset;
    logic             zero_to_ff;
  } cfg_t;

  // Per-byte decision of the position tracker.
  typedef struct packed {
    logic emit;
    logic row_end;
    logic image_end;
  } pos_status_t;

  // Last position of a span; zero acts as one, values above the maximum clamp.
  function automatic logic [POS_W-1:0] span_last(input logic [SPAN_W-1:0] v);
    logic [SPAN_W-1:0] dec;
    dec = v - SPAN_W'(1);
    if (v == '0) begin
      span_last = '0;
    end else if (v > SPAN_W'(MAX_SPAN)) begin
      span_last = '1;
    end else begin
      span_last = dec[POS_W-1:0];
    end
  endfunction

endpackage

/* rtl/core/npu_cfg.sv */
// ----------------------------------------------------------------------------
// npu_cfg
// Configuration registers and the row geometry derived from them.
// ----------------------------------------------------------------------------
module npu_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [npu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [npu_pkg::CFG_DATA_W-1:0]    cfg_data,
  output npu_pkg::cfg_t                     cfg
);

  logic [npu_pkg::SPAN_W-1:0] row_bytes;
  logic [npu_pkg::SPAN_W-1:0] row_count;
  logic [npu_pkg::PIX_W-1:0]  palette_offset;
  logic                       zero_to_ff;
  logic                       drop_last_four;
  logic [npu_pkg::POS_W-1:0]  last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes      <= npu_pkg::ROW_BYTES_RESET;
      row_count      <= npu_pkg::ROW_COUNT_RESET;
      palette_offset <= '0;
      zero_to_ff     <= 1'b0;
      drop_last_four <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        npu_pkg::REG_ROW_BYTES:      row_bytes      <= cfg_data;
        npu_pkg::REG_ROW_COUNT:      row_count      <= cfg_data;
        npu_pkg::REG_PALETTE_OFFSET: palette_offset <= cfg_data[npu_pkg::PIX_W-1:0];
        npu_pkg::REG_ZERO_TO_FF:     zero_to_ff     <= cfg_data[0];
        npu_pkg::REG_DROP_LAST_FOUR: drop_last_four <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign last_col = npu_pkg::span_last(row_bytes);

  always_comb begin
    cfg.last_col       = last_col;
    cfg.last_row       = npu_pkg::span_last(row_count);
    cfg.drop           = drop_last_four;
    cfg.palette_offset = palette_offset;
    cfg.zero_to_ff     = zero_to_ff;
    // With dropping, the last two bytes of a row give nothing.
    cfg.has_emit       = !drop_last_four || (last_col >= npu_pkg::POS_W'(2));
    if (!drop_last_four) begin
      cfg.emit_last = last_col;
    end else if (last_col >= npu_pkg::POS_W'(2)) begin
      cfg.emit_last = last_col - npu_pkg::POS_W'(2);
    end else begin
      cfg.emit_last = '0;
    end
  end

endmodule

/* rtl/core/npu_pos.sv */
// ----------------------------------------------------------------------------
// npu_pos
// Column and row position counters with the row and image end markers.
// ----------------------------------------------------------------------------
module npu_pos (
  input  logic                  clk,
  input  logic                  rst,
  input  npu_pkg::cfg_t         cfg,
  input  logic                  advance,
  output npu_pkg::pos_status_t  status
);

  logic [npu_pkg::POS_W-1:0] column_position;
  logic [npu_pkg::POS_W-1:0] row_position;
  logic                      col_wrap;
  logic                      row_last;
  logic                      rend;

  assign col_wrap = column_position >= cfg.last_col;
  assign row_last = row_position >= cfg.last_row;
  assign rend     = (column_position == cfg.emit_last) || (!cfg.drop && col_wrap);

  always_comb begin
    status.emit      = !cfg.drop || (cfg.has_emit && column_position <= cfg.emit_last);
    status.row_end   = rend;
    status.image_end = rend && row_last;
  end

  // A counter left past its end by a register change wraps on the next byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (advance) begin
      if (col_wrap) begin
        column_position <= '0;
        row_position    <= row_last ? '0 : row_position + npu_pkg::POS_W'(1);
      end else begin
        column_position <= column_position + npu_pkg::POS_W'(1);
      end
    end
  end

endmodule

/* rtl/core/npu_expand.sv */
// ----------------------------------------------------------------------------
// npu_expand
// Expands the two nibbles of a packed byte into 8-bit palette indexes.
// ----------------------------------------------------------------------------
module npu_expand (
  input  npu_pkg::cfg_t               cfg,
  input  logic [7:0]                  packed_byte,
  output logic [npu_pkg::PIX_W-1:0]   left_pixel,
  output logic [npu_pkg::PIX_W-1:0]   right_pixel
);

  function automatic logic [npu_pkg::PIX_W-1:0] expand(
    input logic [npu_pkg::NIB_W-1:0] nib,
    input npu_pkg::cfg_t             c
  );
    if (nib == '0) begin
      expand = c.zero_to_ff ? npu_pkg::ZERO_PIX_HIGH : npu_pkg::ZERO_PIX_LOW;
    end else begin
      expand = npu_pkg::PIX_W'(nib) + c.palette_offset;
    end
  endfunction

  assign left_pixel  = expand(packed_byte[7:4], cfg);
  assign right_pixel = expand(packed_byte[3:0], cfg);

endmodule

/* rtl/core/nibble_pixel_unpack.sv */
// ----------------------------------------------------------------------------
// nibble_pixel_unpack
// Expands packed 4-bit pixels into 8-bit palette indexes, two per word.
// ----------------------------------------------------------------------------
// Each input word is one packed byte carrying two pixels, the high nibble being
// the left pixel. A nonzero nibble becomes (nibble + palette_offset) mod 256 and
// a zero nibble becomes 0, or 255 when zero_to_ff is set. The block counts bytes
// per row and rows per image: tlast marks the last pair of a row and tuser the
// last pair of the image. With drop_last_four set, the last two bytes of every
// row give no output word but still advance the counters. A word passes through
// an input register and a result register; one word is taken every clock as
// long as the output side keeps up, and the result register lets a new word
// enter while the previous result still waits. Configuration must be written
// through cfg_wen/cfg_index/cfg_data while no word is in flight, which the
// block does not enforce. Widths in bytes are expected to be even.
// ----------------------------------------------------------------------------
module nibble_pixel_unpack (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [npu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [npu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] packed_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // [7:0] left_pixel, [15:8] right_pixel
  output logic                              m_tlast,   // row_end
  output logic                              m_tuser    // image_end
);

  npu_pkg::cfg_t              cfg;
  npu_pkg::pos_status_t       status;
  logic                       in_valid;
  logic [7:0]                 in_byte;
  logic                       out_free;
  logic                       advance;
  logic [npu_pkg::PIX_W-1:0]  left_pixel;
  logic [npu_pkg::PIX_W-1:0]  right_pixel;

  npu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The counters move once per byte, when it leaves the input register.
  npu_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .status  (status)
  );

  npu_expand u_expand (
    .cfg         (cfg),
    .packed_byte (in_byte),
    .left_pixel  (left_pixel),
    .right_pixel (right_pixel)
  );

  // The result register can take a word when it is empty or being drained.
  // A dropped byte needs no room there and always leaves at once.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!status.emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && status.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && status.emit) begin
      m_tdata <= {right_pixel, left_pixel};
      m_tlast <= status.row_end;
      m_tuser <= status.image_end;
    end
  end

endmodule

/* rtl/core/npu_checker.sv */
// ----------------------------------------------------------------------------
// npu_checker
// Port-level checks for the nibble pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module npu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [15:0]                       m_tdata,
  input logic                              m_tlast,
  input logic                              m_tuser
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // The image end always falls on a row end.
  a_image_on_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser || m_tlast))
    else $error("image end without row end");

  // The input side only stalls behind a waiting output word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while output is empty");

  // A stalled output word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output word changed");

endmodule

bind nibble_pixel_unpack npu_checker u_npu_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nibble pixel unpacker.
// ----------------------------------------------------------------------------
// Packed bytes are queued by a stimulus process and handed out by a driver
// that follows the input stream handshake. Each accepted byte runs through a
// local model of the unpacker. The model holds its own copy of the settings
// and of the column and row positions. Any pair the model predicts is queued.
// A monitor compares every output word with the oldest predicted pair, field
// by field. Settings change only while the block is idle. Both sides of the
// stream idle at random, in three phases: the receiver mostly stalled, then the
// sender mostly stalled, then neither stalled. Short directed runs come
// first. After them come random runs with random settings, mostly small
// images. One long run covers the widest row.
// ----------------------------------------------------------------------------
module testbench;

  // The datapath is two registers deep. A dropped byte gives no word, so the
  // bench lets the pipe settle before it touches the settings.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 450;

  typedef struct packed {
    logic [npu_pkg::PIX_W-1:0] left;
    logic [npu_pkg::PIX_W-1:0] right;
    logic                      row_end;
    logic                      image_end;
  } pixel_pair_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_wen   = 1'b0;
  logic [npu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [npu_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [15:0]                    m_tdata;
  logic                           m_tlast;
  logic                           m_tuser;

  nibble_pixel_unpack u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #1 clk = ~clk;

  // Bytes still to be sent, and the pairs predicted for bytes already taken.
  logic [7:0]  pending_bytes[$];
  pixel_pair_t expected_pairs[$];

  // Model copy of the settings and of the position counters.
  logic [npu_pkg::SPAN_W-1:0] mdl_row_bytes = npu_pkg::ROW_BYTES_RESET;
  logic [npu_pkg::SPAN_W-1:0] mdl_row_count = npu_pkg::ROW_COUNT_RESET;
  logic [npu_pkg::PIX_W-1:0]  mdl_palette   = '0;
  logic                       mdl_zero_ff   = 1'b0;
  logic                       mdl_drop      = 1'b0;
  logic [npu_pkg::POS_W-1:0]  mdl_col       = '0;
  logic [npu_pkg::POS_W-1:0]  mdl_row       = '0;

  int  src_idle_pct  = 33;
  int  snk_idle_pct  = 59;
  bit  sender_hold   = 1'b0;
  bit  byte_taken    = 1'b0;
  int  cycle_count   = 0;
  int  fail_count    = 0;
  int  bytes_taken   = 0;
  int  pairs_checked = 0;
  int  row_marks     = 0;
  int  image_marks   = 0;

  // A span register of zero acts as one. Values past the maximum act as the maximum.
  function automatic int unsigned span_of(input logic [npu_pkg::SPAN_W-1:0] v);
    if (v == '0) return 1;
    if (v > npu_pkg::SPAN_W'(npu_pkg::MAX_SPAN)) return npu_pkg::MAX_SPAN;
    return {21'd0, v};
  endfunction

  function automatic logic [npu_pkg::PIX_W-1:0] expand_pixel(
    input logic [npu_pkg::NIB_W-1:0] nib
  );
    if (nib == '0) return mdl_zero_ff ? npu_pkg::ZERO_PIX_HIGH : npu_pkg::ZERO_PIX_LOW;
    return npu_pkg::PIX_W'(nib) + mdl_palette;
  endfunction

  // Advances the model by one byte. Returns 1 when the byte yields a pair.
  function automatic bit unpack_byte(input logic [7:0] b, output pixel_pair_t pair);
    int unsigned cols, rows, last_col, last_row, emit_last;
    bit          col_wrap, row_last, emits, at_row_end;
    cols     = span_of(mdl_row_bytes);
    rows     = span_of(mdl_row_count);
    last_col = cols - 1;
    last_row = rows - 1;
    col_wrap = (mdl_col >= last_col);
    row_last = (mdl_row >= last_row);
    if (mdl_drop) begin
      // The last two bytes of each row are dropped. Short rows lose every byte.
      emits     = (cols > 2) && (mdl_col <= cols - 3);
      emit_last = (cols > 2) ? cols - 3 : 0;
    end else begin
      emits     = 1'b1;
      emit_last = last_col;
    end
    pair = '0;
    if (emits) begin
      at_row_end     = (mdl_col == emit_last) || (!mdl_drop && col_wrap);
      pair.left      = expand_pixel(b[7:4]);
      pair.right     = expand_pixel(b[3:0]);
      pair.row_end   = at_row_end;
      pair.image_end = at_row_end && row_last;
    end
    // A position left at or past its end by a settings change wraps here as well.
    if (col_wrap) begin
      mdl_col = '0;
      mdl_row = row_last ? '0 : mdl_row + npu_pkg::POS_W'(1);
    end else begin
      mdl_col = mdl_col + npu_pkg::POS_W'(1);
    end
    return emits;
  endfunction

  // Driver. A word that is offered stays on the bus until it is taken. A new
  // word goes out only when the random idle draw allows it and no hold-off is
  // set.
  always @(negedge clk) begin
    if (!(s_tvalid && !byte_taken)) begin
      if (pending_bytes.size() != 0 && !sender_hold &&
          $urandom_range(99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Monitor. It predicts on every byte the block accepts and checks every word
  // it sends out. Both are sampled at the rising edge.
  always @(posedge clk) begin : monitor
    pixel_pair_t want;
    pixel_pair_t got;
    byte_taken = s_tvalid && s_tready && !rst;
    if (byte_taken) begin
      bytes_taken++;
      if (unpack_byte(s_tdata, want)) expected_pairs.push_back(want);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = '{left: m_tdata[7:0], right: m_tdata[15:8], row_end: m_tlast,
              image_end: m_tuser};
      if (expected_pairs.size() == 0) begin
        $error("output word with no pair expected: tdata %0h", m_tdata);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        pairs_checked++;
        if (got.row_end) row_marks++;
        if (got.image_end) image_marks++;
        if (got.left !== want.left) begin
          $error("left_pixel: expected %0h, actual %0h", want.left, got.left);
          fail_count++;
        end
        if (got.right !== want.right) begin
          $error("right_pixel: expected %0h, actual %0h", want.right, got.right);
          fail_count++;
        end
        if (got.row_end !== want.row_end) begin
          $error("row_end: expected %0d, actual %0d", want.row_end, got.row_end);
          fail_count++;
        end
        if (got.image_end !== want.image_end) begin
          $error("image_end: expected %0d, actual %0d", want.image_end, got.image_end);
          fail_count++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One register write. The model copy applies the same masking as the block.
  task automatic write_reg(input logic [npu_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [npu_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      npu_pkg::REG_ROW_BYTES:      mdl_row_bytes = data[npu_pkg::SPAN_W-1:0];
      npu_pkg::REG_ROW_COUNT:      mdl_row_count = data[npu_pkg::SPAN_W-1:0];
      npu_pkg::REG_PALETTE_OFFSET: mdl_palette   = data[npu_pkg::PIX_W-1:0];
      npu_pkg::REG_ZERO_TO_FF:     mdl_zero_ff   = data[0];
      npu_pkg::REG_DROP_LAST_FOUR: mdl_drop      = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [npu_pkg::CFG_DATA_W-1:0] row_bytes,
                                input logic [npu_pkg::CFG_DATA_W-1:0] row_count,
                                input logic [npu_pkg::CFG_DATA_W-1:0] palette,
                                input logic [npu_pkg::CFG_DATA_W-1:0] zero_ff,
                                input logic [npu_pkg::CFG_DATA_W-1:0] drop);
    write_reg(npu_pkg::REG_ROW_BYTES, row_bytes);
    write_reg(npu_pkg::REG_ROW_COUNT, row_count);
    write_reg(npu_pkg::REG_PALETTE_OFFSET, palette);
    write_reg(npu_pkg::REG_ZERO_TO_FF, zero_ff);
    write_reg(npu_pkg::REG_DROP_LAST_FOUR, drop);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Random settings. Rows and images are mostly small so that row and image
  // marks come often. The extremes and the out-of-range values are mixed in.
  // Unused upper data bits are random garbage.
  task automatic random_settings();
    logic [npu_pkg::CFG_DATA_W-1:0] rb, rc, pal, zf, dr;
    case ($urandom_range(9))
      0:       rb = '0;
      1:       rb = 11'd1;
      2:       rb = 11'd2;
      3:       rb = npu_pkg::CFG_DATA_W'($urandom_range(2047, 1025));
      default: rb = npu_pkg::CFG_DATA_W'($urandom_range(12, 1));
    endcase
    case ($urandom_range(9))
      0:       rc = '0;
      1:       rc = 11'd1;
      2:       rc = $urandom_range(1) ? 11'd1024 : 11'd2047;
      default: rc = npu_pkg::CFG_DATA_W'($urandom_range(6, 1));
    endcase
    pal = npu_pkg::CFG_DATA_W'($urandom_range(2047));
    case ($urandom_range(5))
      0:       pal[7:0] = 8'h00;
      1:       pal[7:0] = 8'hFF;
      default: ;
    endcase
    zf = npu_pkg::CFG_DATA_W'($urandom_range(2047));
    dr = npu_pkg::CFG_DATA_W'($urandom_range(2047));
    dr[0] = ($urandom_range(2) == 0);
    apply_settings(rb, rc, pal, zf, dr);
  endtask

  // Biased toward zero nibbles, which take a separate path in the expansion,
  // and toward all-ones nibbles.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return {4'h0, 4'($urandom_range(15))};
      3:       return {4'($urandom_range(15)), 4'h0};
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Returns once every byte is sent, every pair has arrived and the pipe has
  // emptied.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_tvalid || expected_pairs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_directed(input logic [7:0] bytes[]);
    foreach (bytes[i]) pending_bytes.push_back(bytes[i]);
    wait_idle();
  endtask

  // Sends a run of random bytes. With hold-off set, the sender pauses halfway
  // until every predicted pair has come out.
  task automatic send_random(input int count, input bit hold_off);
    repeat (count) pending_bytes.push_back(random_byte());
    if (hold_off) begin
      while (pending_bytes.size() > count / 2) @(posedge clk);
      sender_hold = 1'b1;
      while (s_tvalid || expected_pairs.size() != 0) @(posedge clk);
      sender_hold = 1'b0;
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int  sent;
    int  run_len;
    bit  held;
    sent = 0;
    held = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: nibble extremes, zero nibbles on each side, offset zero.
    send_directed('{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h10, 8'h5A, 8'hA5});

    // A two-byte row leaves the column position past its end. Zero nibbles map
    // to 255, and an offset of 255 wraps nonzero nibbles around.
    apply_settings(11'd2, 11'd2, 11'hFF, 11'd1, 11'd0);
    send_directed('{8'h00, 8'h1F, 8'h0E, 8'h21, 8'hF0, 8'h10});

    // Three-byte rows with dropping: only the first byte of each row emits.
    apply_settings(11'd3, 11'd1, 11'h80, 11'd0, 11'd1);
    send_directed('{8'h7F, 8'h81, 8'h08, 8'hC3});

    // Zero span registers act as one: every byte ends a row and the image.
    apply_settings(11'd0, 11'd0, 11'h03, 11'd1, 11'd0);
    send_directed('{8'h00, 8'hFE, 8'h12});

    // A two-byte row with dropping emits nothing at all.
    apply_settings(11'd2, 11'd3, 11'h03, 11'd1, 11'd1);
    send_directed('{8'h44, 8'h00, 8'hFF});

    // Random runs. Each phase of idling covers about a third of the bytes.
    while (sent < RANDOM_BYTES) begin
      if (sent < RANDOM_BYTES / 3) begin
        src_idle_pct = 33;
        snk_idle_pct = 59;
      end else if (sent < 2 * RANDOM_BYTES / 3) begin
        src_idle_pct = 59;
        snk_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_settings();
      run_len = $urandom_range(120, 20);
      send_random(run_len, !held && sent >= RANDOM_BYTES / 2);
      if (sent >= RANDOM_BYTES / 2) held = 1'b1;
      sent += run_len;
    end

    // The widest row, crossed once, in a two-row image.
    apply_settings(11'd1024, 11'd2, npu_pkg::CFG_DATA_W'($urandom_range(2047)),
                   npu_pkg::CFG_DATA_W'($urandom_range(1)),
                   npu_pkg::CFG_DATA_W'($urandom_range(1)));
    send_random(1030, 1'b0);

    if (expected_pairs.size() != 0) begin
      $error("%0d predicted pairs never came out", expected_pairs.size());
      fail_count++;
    end
    $display("Sent %0d packed bytes in %0d cycles; checked %0d pixel pairs.",
             bytes_taken, cycle_count, pairs_checked);
    $display("Saw %0d row ends and %0d image ends across random row and image sizes.",
             row_marks, image_marks);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
